// ===== design/sqvs_pkg.sv =====
`default_nettype none

package sqvs_pkg;

    // default rotation resolution, steps per turn
    localparam int ANGLE_STEPS_DEF = 4096;

    // configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 14;
    localparam logic [CFG_AW-1:0] CFG_VP_W = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_VP_H = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_TX_W = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_TX_H = 3'd3;

    localparam logic [CFG_DW-1:0] VP_W_RST = 14'd1280;
    localparam logic [CFG_DW-1:0] VP_H_RST = 14'd720;
    localparam logic [CFG_DW-1:0] TX_W_RST = 14'd256;
    localparam logic [CFG_DW-1:0] TX_H_RST = 14'd256;

    // pipeline depths of the angle front end
    localparam int PH_LAT = 2;
    localparam int SC_LAT = 4;

    // divider geometry: biased numerator, denominator, remainder, quotient
    localparam int NUM_W = 41;
    localparam int DEN_W = 20;
    localparam int REM_W = 38;
    localparam int QUO_W = 18;

    // quarter sine polynomial in q14
    localparam logic [14:0] ONE_Q14 = 15'd16384;
    localparam logic [15:0] QUARTER = 16'h4000;
    localparam logic [14:0] SIN_C1  = 15'd25736;
    localparam logic [13:0] SIN_C2  = 14'd10512;
    localparam logic [10:0] SIN_C3  = 11'd1160;

    localparam logic signed [15:0] S16_MAX = 16'sh7fff;
    localparam logic signed [15:0] S16_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic [14:0]        dest_w;
        logic [14:0]        dest_h;
        logic [11:0]        angle;
        logic               use_src;
        logic signed [15:0] src_x;
        logic signed [15:0] src_y;
        logic [14:0]        src_w;
        logic [14:0]        src_h;
        logic [31:0]        color;
    } t_item;

    typedef struct packed {
        t_item      item;
        logic [1:0] k;
    } t_tag;

    typedef struct packed {
        logic [1:0]  k;
        logic        use_src;
        logic [31:0] color;
    } t_otag;

    // clamp to signed 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        if (v > 20'sd32767) begin
            sat16 = S16_MAX;
        end else if (v < -20'sd32768) begin
            sat16 = S16_MIN;
        end else begin
            sat16 = v[15:0];
        end
    endfunction

    // a size of zero counts as one
    function automatic logic [CFG_DW-1:0] size_of(input logic [CFG_DW-1:0] r);
        size_of = (r == '0) ? CFG_DW'(1) : r;
    endfunction

endpackage

`default_nettype wire

// ===== design/sqvs_phase.sv =====
`default_nettype none

module sqvs_phase #(
    parameter int ANGLE_STEPS = sqvs_pkg::ANGLE_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [11:0] i_angle,
    output logic        o_vld,
    output logic [15:0] o_ph
);
    import sqvs_pkg::*;

    localparam logic [16:0] STEPS = 17'(ANGLE_STEPS);
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / ANGLE_STEPS);

    logic        r_vld [0:PH_LAT-1];
    logic [11:0] r_ang;
    logic [15:0] r_q0;
    logic [15:0] r_ph;
    logic [19:0] w_a;
    logic [44:0] w_mul;
    logic [32:0] w_prod;
    logic [33:0] w_rem;

    // wrap the angle into one turn, quotient is at most fifteen
    always_comb begin
        w_a = {8'd0, i_angle};
        for (int j = 3; j >= 0; j--) begin
            if (w_a >= (20'(STEPS) << j)) begin
                w_a = w_a - (20'(STEPS) << j);
            end
        end
        w_mul = 45'(w_a[11:0]) * 45'(RECIP);
    end

    // estimate may be one short, fix with the remainder
    assign w_prod = 33'(r_q0) * 33'(STEPS);
    assign w_rem  = 34'({r_ang, 16'd0}) - 34'(w_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
            r_vld[1] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            r_vld[1] <= r_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ang <= w_a[11:0];
        r_q0  <= w_mul[31:16];
        r_ph  <= (w_rem >= 34'(STEPS)) ? r_q0 + 16'd1 : r_q0;
    end

    assign o_vld = r_vld[PH_LAT-1];
    assign o_ph  = r_ph;

endmodule

`default_nettype wire

// ===== design/sqvs_sincos.sv =====
`default_nettype none

module sqvs_sincos (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic [15:0]        i_ph,
    output logic               o_vld,
    output logic signed [15:0] o_sin,
    output logic signed [15:0] o_cos
);
    import sqvs_pkg::*;

    logic               r_vld [0:SC_LAT-1];
    logic signed [15:0] r_res [0:1];

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SC_LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int i = 1; i < SC_LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // lane 0 sine, lane 1 cosine a quarter turn ahead
    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [15:0] w_ph;
        logic [14:0] w_z;
        logic [29:0] w_zz;
        logic [24:0] w_m1;
        logic [13:0] w_t1;
        logic [28:0] w_m2;
        logic [14:0] w_t2;
        logic [29:0] w_m3;
        logic [15:0] w_p;
        logic [14:0] w_pc;
        logic [14:0] r_z1, r_z2, r_z3;
        logic [14:0] r_q1, r_q2;
        logic [13:0] r_t1;
        logic [14:0] r_t2;
        logic        r_n1, r_n2, r_n3;

        assign w_ph = (l == 0) ? i_ph : i_ph + QUARTER;
        // odd quadrants run backwards
        assign w_z  = w_ph[14] ? ONE_Q14 - {1'b0, w_ph[13:0]} : {1'b0, w_ph[13:0]};
        assign w_zz = 30'(w_z) * 30'(w_z);
        assign w_m1 = 25'(SIN_C3) * 25'(r_q1);
        assign w_t1 = SIN_C2 - 14'(w_m1[24:14]);
        assign w_m2 = 29'(r_t1) * 29'(r_q2);
        assign w_t2 = SIN_C1 - 15'(w_m2[28:14]);
        assign w_m3 = 30'(r_z3) * 30'(r_t2);
        assign w_p  = w_m3[29:14];
        // clamp so the quadrant ends hit one exactly
        assign w_pc = (w_p > 16'(ONE_Q14)) ? ONE_Q14 : w_p[14:0];

        always_ff @(posedge i_clk) begin
            r_z1 <= w_z;
            r_q1 <= w_zz[28:14];
            r_n1 <= w_ph[15];
            r_z2 <= r_z1;
            r_q2 <= r_q1;
            r_n2 <= r_n1;
            r_t1 <= w_t1;
            r_z3 <= r_z2;
            r_n3 <= r_n2;
            r_t2 <= w_t2;
            r_res[l] <= r_n3 ? -$signed({1'b0, w_pc}) : $signed({1'b0, w_pc});
        end
    end

    assign o_vld = r_vld[SC_LAT-1];
    assign o_sin = r_res[0];
    assign o_cos = r_res[1];

endmodule

`default_nettype wire

// ===== design/sqvs_div.sv =====
`default_nettype none

module sqvs_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic signed [sqvs_pkg::NUM_W-1:0]   i_num,
    input  logic [sqvs_pkg::DEN_W-1:0]          i_den,
    output logic                                o_vld,
    output logic signed [sqvs_pkg::QUO_W-1:0]   o_quo,
    output logic                                o_lo,
    output logic                                o_hi
);
    import sqvs_pkg::*;

    logic             r_vld [0:QUO_W];
    logic             r_lo  [0:QUO_W];
    logic             r_hi  [0:QUO_W];
    logic [QUO_W-1:0] r_quo [0:QUO_W];
    logic [REM_W-1:0] r_rem [0:QUO_W-1];
    logic [DEN_W-1:0] r_den [0:QUO_W-1];
    logic             w_lo;
    logic             w_hi;
    logic [NUM_W-1:0] w_top;

    // out of range on either side goes straight to saturation
    assign w_top = {{(NUM_W-DEN_W-QUO_W){1'b0}}, i_den, {QUO_W{1'b0}}};
    assign w_lo  = i_num[NUM_W-1];
    assign w_hi  = !w_lo && ($unsigned(i_num) >= w_top);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo[0]  <= w_lo;
        r_hi[0]  <= w_hi;
        r_quo[0] <= '0;
        r_rem[0] <= i_num[REM_W-1:0];
        r_den[0] <= i_den;
    end

    // one quotient bit per stage, msb first
    for (genvar s = 1; s <= QUO_W; s++) begin : g_stage
        localparam int B = QUO_W - s;
        logic [REM_W-1:0] w_sh;
        logic             w_ge;

        assign w_sh = {{(REM_W-DEN_W){1'b0}}, r_den[s-1]} << B;
        assign w_ge = r_rem[s-1] >= w_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_lo[s]  <= r_lo[s-1];
            r_hi[s]  <= r_hi[s-1];
            r_quo[s] <= r_quo[s-1] | (QUO_W'(w_ge) << B);
        end

        if (s < QUO_W) begin : g_keep
            always_ff @(posedge i_clk) begin
                r_rem[s] <= w_ge ? r_rem[s-1] - w_sh : r_rem[s-1];
                r_den[s] <= r_den[s-1];
            end
        end
    end

    // remove the bias of half the quotient range
    assign o_vld = r_vld[QUO_W];
    assign o_quo = {~r_quo[QUO_W][QUO_W-1], r_quo[QUO_W][QUO_W-2:0]};
    assign o_lo  = r_lo[QUO_W];
    assign o_hi  = r_hi[QUO_W];

endmodule

`default_nettype wire

// ===== design/sprite_quad_vertex_setup.sv =====
`default_nettype none

// channel   signals                               direction  handshake
// sprite    start, busy, i_dest_* .. i_color_rgba in         start & !busy
// vertex    o_vertex_valid, o_vertex_index ..     out        strobe, one cycle
// config    i_cfg_we, i_cfg_addr, i_cfg_data      in         write enable
//
// each sprite gives four vertices: the sequencer issues one vertex per clock
// into the pipeline, and the single vertex channel carries one per clock.
// the pipeline depth is set by the 18 stage restoring dividers.
// synchronous active low reset clears sequencer and valid bits, presets config.
// the receiver cannot stall, so the pipeline never holds.

module sprite_quad_vertex_setup #(
    parameter int ANGLE_STEPS = sqvs_pkg::ANGLE_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [sqvs_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [sqvs_pkg::CFG_DW-1:0]   i_cfg_data,
    input  logic signed [15:0]            i_dest_x,
    input  logic signed [15:0]            i_dest_y,
    input  logic [14:0]                   i_dest_w,
    input  logic [14:0]                   i_dest_h,
    input  logic [11:0]                   i_angle,
    input  logic                          i_use_source_rect,
    input  logic signed [15:0]            i_src_x,
    input  logic signed [15:0]            i_src_y,
    input  logic [14:0]                   i_src_w,
    input  logic [14:0]                   i_src_h,
    input  logic [31:0]                   i_color_rgba,
    output logic                          o_vertex_valid,
    output logic [1:0]                    o_vertex_index,
    output logic signed [15:0]            o_ndc_x,
    output logic signed [15:0]            o_ndc_y,
    output logic signed [15:0]            o_tex_u,
    output logic signed [15:0]            o_tex_v,
    output logic [31:0]                   o_vertex_color,
    output logic                          o_last_vertex
);
    import sqvs_pkg::*;

    localparam int TAG_D = PH_LAT + SC_LAT;

    logic [CFG_DW-1:0]  r_vp_w, r_vp_h, r_tx_w, r_tx_h;
    logic               r_act;
    logic [1:0]         r_k;
    t_item              r_item;
    t_item              w_item;
    t_tag               w_tag0;
    t_tag               r_tag [0:TAG_D-1];
    t_tag               w_t;
    logic               w_acc;

    logic               w_ph_vld;
    logic [15:0]        w_ph;
    logic               w_sc_vld;
    logic signed [15:0] w_sin, w_cos;

    logic signed [15:0] w_rx, w_ry;
    logic signed [17:0] w_cx, w_cy;
    logic signed [16:0] w_eu, w_ev;
    logic               r_p_vld;
    logic signed [31:0] r_p_crx, r_p_sry, r_p_srx, r_p_cry;
    logic signed [17:0] r_p_cx, r_p_cy;
    logic signed [16:0] r_p_eu, r_p_ev;
    t_otag              r_p_otag;

    logic               r_s_vld;
    logic signed [NUM_W-1:0] r_s_num [0:3];
    logic [DEN_W-1:0]   r_s_den [0:3];
    t_otag              r_s_otag;
    t_otag              r_otag [0:QUO_W];
    t_otag              w_o;

    logic               w_d_vld [0:3];
    logic signed [QUO_W-1:0] w_d_quo [0:3];
    logic               w_d_lo  [0:3];
    logic               w_d_hi  [0:3];

    logic [CFG_DW-1:0]  w_szw, w_szh, w_stw, w_sth;
    logic signed [15:0] w_nx, w_ny, w_tu, w_tv;

    logic               r_ovld;
    logic [1:0]         r_oidx;
    logic signed [15:0] r_onx, r_ony, r_otu, r_otv;
    logic [31:0]        r_ocol;
    logic               r_olast;

    // biased numerator for a screen position over the viewport size
    function automatic logic signed [NUM_W-1:0] pos_num(
        input logic signed [17:0] c,
        input logic signed [31:0] a,
        input logic signed [31:0] b,
        input logic               sub,
        input logic [CFG_DW-1:0]  sz
    );
        logic signed [NUM_W-1:0] bb;
        bb = NUM_W'(b) <<< 1;
        pos_num = (NUM_W'(c) <<< 15) + (NUM_W'(a) <<< 1) + (sub ? -bb : bb)
                + $signed(NUM_W'({sz, 4'b0})) + $signed(NUM_W'({sz, 22'b0}));
    endfunction

    // biased numerator for a texture edge over the texture size
    function automatic logic signed [NUM_W-1:0] tex_num(
        input logic signed [16:0] e,
        input logic [CFG_DW-1:0]  sz
    );
        tex_num = (NUM_W'(e) <<< 11) + $signed(NUM_W'(sz))
                + $signed(NUM_W'({sz, 18'b0}));
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp_w <= VP_W_RST;
            r_vp_h <= VP_H_RST;
            r_tx_w <= TX_W_RST;
            r_tx_h <= TX_H_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_VP_W: r_vp_w <= i_cfg_data;
                CFG_VP_H: r_vp_h <= i_cfg_data;
                CFG_TX_W: r_tx_w <= i_cfg_data;
                CFG_TX_H: r_tx_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sprite beat capture
    always_comb begin
        w_item.dest_x  = i_dest_x;
        w_item.dest_y  = i_dest_y;
        w_item.dest_w  = i_dest_w;
        w_item.dest_h  = i_dest_h;
        w_item.angle   = i_angle;
        w_item.use_src = i_use_source_rect;
        w_item.src_x   = i_src_x;
        w_item.src_y   = i_src_y;
        w_item.src_w   = i_src_w;
        w_item.src_h   = i_src_h;
        w_item.color   = i_color_rgba;
    end

    // corner sequencer, takes the next sprite while issuing the last corner
    assign busy  = r_act && (r_k != 2'd3);
    assign w_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_k   <= 2'd0;
        end else if (w_acc) begin
            r_act <= 1'b1;
            r_k   <= 2'd0;
        end else if (r_act) begin
            r_act <= (r_k != 2'd3);
            r_k   <= r_k + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item <= w_item;
        end
    end

    // corner data alongside the angle front end
    always_comb begin
        w_tag0.item = r_item;
        w_tag0.k    = r_k;
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= w_tag0;
        for (int i = 1; i < TAG_D; i++) begin
            r_tag[i] <= r_tag[i-1];
        end
    end

    sqvs_phase #(
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_act),
        .i_angle (r_item.angle),
        .o_vld   (w_ph_vld),
        .o_ph    (w_ph)
    );

    sqvs_sincos u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_ph_vld),
        .i_ph    (w_ph),
        .o_vld   (w_sc_vld),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // corner offsets and rotation products
    assign w_t  = r_tag[TAG_D-1];
    assign w_rx = w_t.k[0] ? $signed({1'b0, w_t.item.dest_w})
                           : -$signed({1'b0, w_t.item.dest_w});
    assign w_ry = w_t.k[1] ? $signed({1'b0, w_t.item.dest_h})
                           : -$signed({1'b0, w_t.item.dest_h});
    assign w_cx = (18'(w_t.item.dest_x) <<< 1) + $signed({3'b000, w_t.item.dest_w});
    assign w_cy = (18'(w_t.item.dest_y) <<< 1) + $signed({3'b000, w_t.item.dest_h});
    assign w_eu = w_t.k[0] ? 17'(w_t.item.src_x) + $signed({2'b00, w_t.item.src_w})
                           : 17'(w_t.item.src_x);
    assign w_ev = w_t.k[1] ? 17'(w_t.item.src_y) + $signed({2'b00, w_t.item.src_h})
                           : 17'(w_t.item.src_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= w_sc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_crx          <= w_cos * w_rx;
        r_p_sry          <= w_sin * w_ry;
        r_p_srx          <= w_sin * w_rx;
        r_p_cry          <= w_cos * w_ry;
        r_p_cx           <= w_cx;
        r_p_cy           <= w_cy;
        r_p_eu           <= w_eu;
        r_p_ev           <= w_ev;
        r_p_otag.k       <= w_t.k;
        r_p_otag.use_src <= w_t.item.use_src;
        r_p_otag.color   <= w_t.item.color;
    end

    // divider operands
    assign w_szw = size_of(r_vp_w);
    assign w_szh = size_of(r_vp_h);
    assign w_stw = size_of(r_tx_w);
    assign w_sth = size_of(r_tx_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else begin
            r_s_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s_num[0] <= pos_num(r_p_cx, r_p_crx, r_p_sry, 1'b1, w_szw);
        r_s_num[1] <= pos_num(r_p_cy, r_p_srx, r_p_cry, 1'b0, w_szh);
        r_s_num[2] <= tex_num(r_p_eu, w_stw);
        r_s_num[3] <= tex_num(r_p_ev, w_sth);
        r_s_den[0] <= DEN_W'({w_szw, 5'b0});
        r_s_den[1] <= DEN_W'({w_szh, 5'b0});
        r_s_den[2] <= DEN_W'({w_stw, 1'b0});
        r_s_den[3] <= DEN_W'({w_sth, 1'b0});
        r_s_otag   <= r_p_otag;
    end

    // lanes x, y, u, v
    for (genvar l = 0; l < 4; l++) begin : g_div
        sqvs_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (r_s_vld),
            .i_num   (r_s_num[l]),
            .i_den   (r_s_den[l]),
            .o_vld   (w_d_vld[l]),
            .o_quo   (w_d_quo[l]),
            .o_lo    (w_d_lo[l]),
            .o_hi    (w_d_hi[l])
        );
    end

    always_ff @(posedge i_clk) begin
        r_otag[0] <= r_s_otag;
        for (int i = 1; i <= QUO_W; i++) begin
            r_otag[i] <= r_otag[i-1];
        end
    end

    // device and texture coordinates with saturation
    assign w_o = r_otag[QUO_W];

    always_comb begin
        if (w_d_lo[0]) begin
            w_nx = S16_MIN;
        end else if (w_d_hi[0]) begin
            w_nx = S16_MAX;
        end else begin
            w_nx = sat16(20'(w_d_quo[0]) - 20'sd16384);
        end
        if (w_d_lo[1]) begin
            w_ny = S16_MAX;
        end else if (w_d_hi[1]) begin
            w_ny = S16_MIN;
        end else begin
            w_ny = sat16(20'sd16384 - 20'(w_d_quo[1]));
        end
        if (!w_o.use_src) begin
            w_tu = w_o.k[0] ? 16'sd16384 : 16'sd0;
        end else if (w_d_lo[2]) begin
            w_tu = S16_MIN;
        end else if (w_d_hi[2]) begin
            w_tu = S16_MAX;
        end else begin
            w_tu = sat16(20'(w_d_quo[2]));
        end
        if (!w_o.use_src) begin
            w_tv = w_o.k[1] ? 16'sd16384 : 16'sd0;
        end else if (w_d_lo[3]) begin
            w_tv = S16_MIN;
        end else if (w_d_hi[3]) begin
            w_tv = S16_MAX;
        end else begin
            w_tv = sat16(20'(w_d_quo[3]));
        end
    end

    // vertex output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= w_d_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_oidx  <= w_o.k;
        r_onx   <= w_nx;
        r_ony   <= w_ny;
        r_otu   <= w_tu;
        r_otv   <= w_tv;
        r_ocol  <= w_o.color;
        r_olast <= (w_o.k == 2'd3);
    end

    assign o_vertex_valid = r_ovld;
    assign o_vertex_index = r_oidx;
    assign o_ndc_x        = r_onx;
    assign o_ndc_y        = r_ony;
    assign o_tex_u        = r_otu;
    assign o_tex_v        = r_otv;
    assign o_vertex_color = r_ocol;
    assign o_last_vertex  = r_olast;

    // checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> busy)
        else $error("busy not raised after a sprite beat");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_d_vld[0] == w_d_vld[1]) && (w_d_vld[0] == w_d_vld[2])
        && (w_d_vld[0] == w_d_vld[3]))
        else $error("divider lanes out of step");

    a_corner_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vertex_valid && (o_vertex_index != 2'd3)) |=>
        (o_vertex_valid && (o_vertex_index == $past(o_vertex_index) + 2'd1)))
        else $error("vertex beats of a sprite not consecutive");

    a_first_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_vertex_valid) |-> (o_vertex_index == 2'd0))
        else $error("vertex run does not open with the left-top corner");

endmodule

`default_nettype wire
